// ===== sv/rle_pkg.sv =====
// Shared types and constants for the RLE byte-to-halfword decoder, used by
// rle_front, rle_cmdq, rle_back and the top level; depends on nothing else.
package rle_pkg;

  // Flag byte bit that marks a run, and the bias added to a run length.
  localparam logic [7:0] RUN_FLAG = 8'h80;
  localparam logic [7:0] RUN_BIAS = 8'd3;

  // Result slots one command can carry: completing word, pair word, flush word.
  localparam int unsigned SLOTS = 3;

  // Command queue depth and its pointer width.
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = 2;

  // Register address map.
  localparam logic ADDR_OUTPUT_SIZE = 1'b0;

  // Decoder phase, one-hot.
  typedef enum logic [2:0] {
    PH_FLAG    = 3'b001,
    PH_RUNVAL  = 3'b010,
    PH_LITERAL = 3'b100
  } phase_t;

  // Fixed-width part of one command; word indexes travel beside it.
  typedef struct packed {
    logic [SLOTS-1:0] last;        // one-hot slot that ends the stream, or zero
    logic [SLOTS-1:0] mask;        // slots that hold a result word
    logic [7:0]       flush_byte;  // low byte of the flush word
    logic [6:0]       pair_count;  // repeat count of the pair word
    logic [15:0]      pair_value;  // two equal run bytes
    logic [15:0]      first_value; // pending low byte completed by this byte
  } cmd_fix_t;

endpackage

// ===== sv/rle_front.sv =====
// RLE decoder front end: parses flag, run value and literal bytes and turns each
// byte with results into one command of up to three result words. Uses rle_pkg.
module rle_front
  import rle_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic [SIZE_BITS-1:0]           size,
  input  logic                           cmd_ready,
  output logic                           cmd_valid,
  output cmd_fix_t                       cmd_fix,
  output logic [SLOTS*SIZE_BITS-1:0]     cmd_idx   // slot 0 index in the lowest bits
);

  localparam int unsigned BPW = SIZE_BITS + 1;

  phase_t         phase, phase_next;
  logic [7:0]     remaining, remaining_next;
  logic [7:0]     pending, pending_next;
  logic [BPW-1:0] produced, produced_next;

  logic           accept;
  logic           odd;
  logic [7:0]     run_cnt;
  logic [6:0]     pairs;
  logic [BPW-1:0] bp_after_first;
  logic [BPW-1:0] bp_end;
  logic [7:0]     pend_end;
  logic [7:0]     rem_dec;
  logic           is_run, is_lit;
  logic           group_end, stream_end;
  logic [SLOTS-1:0] mask;

  assign accept   = in_valid && in_ready;
  assign in_ready = cmd_ready;
  assign is_run   = (phase == PH_RUNVAL);
  assign is_lit   = (phase == PH_LITERAL);
  assign odd      = produced[0];

  // Run arithmetic: a completing byte if the count is odd, then whole pairs.
  assign run_cnt        = remaining - {7'd0, odd};
  assign pairs          = run_cnt[7:1];
  assign bp_after_first = produced + BPW'(odd);
  assign rem_dec        = (remaining != 8'd0) ? remaining - 8'd1 : remaining;

  // End-of-group byte count, pending byte and stream end test.
  always_comb begin
    if (is_run) begin
      bp_end   = produced + BPW'(remaining);
      pend_end = run_cnt[0] ? in_byte : pending;
    end else begin
      bp_end   = produced + BPW'(1);
      pend_end = odd ? 8'd0 : in_byte;
    end
  end

  assign group_end  = is_run || (is_lit && (rem_dec == 8'd0));
  assign stream_end = group_end && (bp_end >= {1'b0, size});

  // Result slots of this byte.
  assign mask[0] = (is_run || is_lit) && odd;
  assign mask[1] = is_run && (pairs != 7'd0);
  assign mask[2] = stream_end && bp_end[0];

  always_comb begin
    cmd_fix.mask        = mask;
    cmd_fix.last[2]     = stream_end && mask[2];
    cmd_fix.last[1]     = stream_end && mask[1] && !mask[2];
    cmd_fix.last[0]     = stream_end && mask[0] && !mask[1] && !mask[2];
    cmd_fix.flush_byte  = pend_end;
    cmd_fix.pair_count  = pairs;
    cmd_fix.pair_value  = {in_byte, in_byte};
    cmd_fix.first_value = {in_byte, pending};
  end

  assign cmd_idx   = {bp_end[SIZE_BITS:1], bp_after_first[SIZE_BITS:1],
                      produced[SIZE_BITS:1]};
  assign cmd_valid = accept && (mask != '0);

  // Parser state update.
  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    pending_next   = pending;
    produced_next  = produced;
    if (accept) begin
      unique case (phase)
        PH_FLAG: begin
          if ((in_byte & RUN_FLAG) != 8'd0) begin
            remaining_next = {1'b0, in_byte[6:0]} + RUN_BIAS;
            phase_next     = PH_RUNVAL;
          end else begin
            remaining_next = in_byte + 8'd1;
            phase_next     = PH_LITERAL;
          end
        end
        PH_RUNVAL: begin
          remaining_next = 8'd0;
          pending_next   = pend_end;
          produced_next  = bp_end;
          phase_next     = PH_FLAG;
        end
        PH_LITERAL: begin
          remaining_next = rem_dec;
          pending_next   = pend_end;
          produced_next  = bp_end;
          if (group_end) begin
            phase_next = PH_FLAG;
          end
        end
        default: begin
          phase_next = PH_FLAG;
        end
      endcase
      // A finished stream clears the counters for the next one.
      if (stream_end) begin
        remaining_next = 8'd0;
        pending_next   = 8'd0;
        produced_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FLAG;
      remaining <= 8'd0;
      pending   <= 8'd0;
      produced  <= '0;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
      pending   <= pending_next;
      produced  <= produced_next;
    end
  end

endmodule

// ===== sv/rle_cmdq.sv =====
// Small register FIFO that holds decoded commands between front and back end.
// Uses the depth constants of rle_pkg.
module rle_cmdq
  import rle_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0]    entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMDQ_PTR_W:0]   count;
  logic                do_push, do_pop;

  assign full    = (count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/rle_back.sv =====
// RLE decoder back end (uses rle_pkg): walks the result slots of the head
// command and presents one result word per ready cycle in an output register.
module rle_back
  import rle_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 24,
  parameter int unsigned OUT_W     = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  cmd_fix_t                   cmd_fix,
  input  logic [SLOTS*SIZE_BITS-1:0] cmd_idx,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [OUT_W-1:0]           out_data,
  output logic                       out_last
);

  logic [SLOTS-1:0]     taken;
  logic [SLOTS-1:0]     rest, sel, after;
  logic                 load;
  logic [15:0]          value;
  logic [6:0]           count;
  logic [SIZE_BITS-1:0] index;

  // Slots still to send, and the lowest of them.
  assign rest  = cmd_fix.mask & ~taken;
  assign sel   = rest & (~rest + 1'b1);
  assign after = rest & ~sel;
  assign load  = cmd_valid && (!out_valid || out_ready);
  assign cmd_pop = load && (after == '0);

  // Select the fields of the chosen slot.
  always_comb begin
    value = {8'd0, cmd_fix.flush_byte};
    count = 7'd1;
    index = cmd_idx[2*SIZE_BITS +: SIZE_BITS];
    if (sel[0]) begin
      value = cmd_fix.first_value;
      index = cmd_idx[0 +: SIZE_BITS];
    end else if (sel[1]) begin
      value = cmd_fix.pair_value;
      count = cmd_fix.pair_count;
      index = cmd_idx[SIZE_BITS +: SIZE_BITS];
    end
  end

  // Slot progress within the head command.
  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (load) begin
      taken <= cmd_pop ? '0 : (taken | sel);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= OUT_W'({index, count, value});
      out_last <= (sel & cmd_fix.last) != '0;
    end
  end

endmodule

// ===== sv/rle_byte_stream_to_halfwords.sv =====
// RLE byte stream to halfword decoder. Compressed bytes (flag, run value or
// literal) enter on the s_ stream at up to one byte per cycle. A run value
// byte gives up to three result words (completing halfword, repeated pair
// with a count, end-of-stream flush) and a literal byte at most one; these
// pass a four-entry command queue and leave on the m_ stream at one word per
// ready cycle, so the output port sets the sustained rate when results
// outnumber input bytes. The stream ends at the first group end where the
// decoded byte total reaches output_size_bytes; that result carries tlast and
// the counters clear. Write output_size_bytes at address 0 only while idle.
module rle_byte_stream_to_halfwords
  import rle_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,  // [7:0] compressed_byte
  // Output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // [15:0] halfword_value, [22:16] repeat_count,
  // [SIZE_BITS+22:23] first_word_index, zero fill above
  output logic [((23+SIZE_BITS+7)/8)*8-1:0] m_tdata,
  output logic              m_tlast
);

  localparam int unsigned OUT_W = ((23 + SIZE_BITS + 7) / 8) * 8;
  localparam int unsigned FIX_W = $bits(cmd_fix_t);
  localparam int unsigned IDX_W = SLOTS * SIZE_BITS;
  localparam int unsigned CMD_W = FIX_W + IDX_W;

  logic [SIZE_BITS-1:0] output_size;
  logic                 cfg_write;

  logic                 f_valid, q_full, q_empty, q_pop;
  cmd_fix_t             f_fix, b_fix;
  logic [IDX_W-1:0]     f_idx, b_idx;
  logic [CMD_W-1:0]     q_head;

  // Configuration register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == ADDR_OUTPUT_SIZE);
  assign prdata    = (paddr[2] == ADDR_OUTPUT_SIZE) ? 32'(output_size) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_size <= '0;
    end else if (cfg_write) begin
      output_size <= pwdata[SIZE_BITS-1:0];
    end
  end

  // Byte parser.
  rle_front #(.SIZE_BITS(SIZE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .size      (output_size),
    .cmd_ready (!q_full),
    .cmd_valid (f_valid),
    .cmd_fix   (f_fix),
    .cmd_idx   (f_idx)
  );

  // Command queue.
  rle_cmdq #(.WIDTH(CMD_W)) u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data ({f_idx, f_fix}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  assign b_fix = cmd_fix_t'(q_head[FIX_W-1:0]);
  assign b_idx = q_head[CMD_W-1:FIX_W];

  // Result word sequencer.
  rle_back #(.SIZE_BITS(SIZE_BITS), .OUT_W(OUT_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd_fix   (b_fix),
    .cmd_idx   (b_idx),
    .cmd_pop   (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

`ifndef ASSERT_OFF
  // Every result word repeats its halfword between one and 65 times.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[22:16] != 7'd0) && (m_tdata[22:16] <= 7'd65))
    else $error("repeat count out of range");

  // Nothing is presented on the output right after reset.
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // A size write reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && (paddr[2] == ADDR_OUTPUT_SIZE)) |=>
      (paddr[2] != ADDR_OUTPUT_SIZE) || (prdata == 32'($past(pwdata[SIZE_BITS-1:0]))))
    else $error("size register readback mismatch");
`endif

endmodule
